// ===== hdl/c2d_pkg.sv =====
// Shared types and constants for the 5x5 streaming convolution.
// Used by c2d_mac, conv2d_5x5_stream and the checker; depends on nothing else.
`default_nettype none

package c2d_pkg;

    localparam int KSIZE          = 5;
    localparam int HALF           = (KSIZE - 1) / 2;
    localparam int NTAPS          = KSIZE * KSIZE;
    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int COEFS_PER_WORD = 4;
    localparam int PROD_W         = COEF_W + PIX_W + 1;
    localparam int PART_W         = PROD_W + 3;
    localparam int SUM_W          = PART_W + 3;
    localparam int LINE_W         = PIX_W * (KSIZE - 1);
    localparam int LW_W           = 11;
    localparam int WCMP_W         = LW_W + 2;
    localparam int ROW_W          = 12;
    localparam int ROW_CNT_W      = 13;
    localparam int COL_W          = 10;
    localparam int VAL_W          = 14;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_COEF_WORDS = 6;

    localparam logic [ROW_CNT_W-1:0] ROW_CAP   = ROW_CNT_W'(4095 + HALF);
    localparam logic [ROW_W-1:0]     ROW_SAT   = '1;
    localparam logic [LW_W-1:0]      LW_RESET  = LW_W'(256);

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TAIL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last_in_frame;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] filtered_value;
        logic [ROW_W-1:0]        center_row;
        logic [COL_W-1:0]        center_col;
        logic                    last_result;
    } t_out_word;

    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic             last;
    } t_meta;

    typedef logic [NTAPS-1:0][PIX_W-1:0]  t_window;
    typedef logic [NTAPS-1:0][COEF_W-1:0] t_coefs;

endpackage

`default_nettype wire

// ===== hdl/c2d_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; holds the line store of the convolution block.
`default_nettype none

module c2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/c2d_mac.sv =====
// Pipelined multiply-accumulate over the 5x5 window with truncation and saturation.
// Depends on c2d_pkg; instantiated by conv2d_5x5_stream.
`default_nettype none

module c2d_mac #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  c2d_pkg::t_meta      i_meta,
    input  c2d_pkg::t_window    i_window,
    input  c2d_pkg::t_coefs     i_coefs,
    output logic                o_valid,
    input  logic                i_stall,
    output c2d_pkg::t_out_word  o_word
);

    import c2d_pkg::*;

    localparam logic signed [SUM_W:0] BIAS  = (SUM_W+1)'((1 << COEF_FRAC_BITS) - 1);
    localparam logic signed [SUM_W:0] Q_MAX = (SUM_W+1)'(8191);
    localparam logic signed [SUM_W:0] Q_MIN = -(SUM_W+1)'(8192);

    logic p_rdy, a_rdy, t_rdy, o_rdy;

    logic r_p_valid, r_a_valid, r_t_valid, r_o_valid;
    t_meta r_p_meta, r_a_meta, r_t_meta;

    logic signed [PROD_W-1:0] r_prod [NTAPS];
    logic signed [PROD_W-1:0] n_prod [NTAPS];
    logic signed [PART_W-1:0] r_part [KSIZE];
    logic signed [PART_W-1:0] n_part [KSIZE];
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W:0]    biased;
    logic signed [SUM_W:0]    quot;
    logic signed [VAL_W-1:0]  n_val;
    t_out_word                r_word;

    assign o_rdy   = !r_o_valid || !i_stall;
    assign t_rdy   = !r_t_valid || o_rdy;
    assign a_rdy   = !r_a_valid || t_rdy;
    assign p_rdy   = !r_p_valid || a_rdy;
    assign o_ready = p_rdy;

    // Tap k pairs coefficient k with the window pixel mirrored through the center.
    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            n_prod[k] = $signed(i_coefs[k]) * $signed({1'b0, i_window[NTAPS-1-k]});
        end
    end

    always_comb begin
        logic signed [PART_W-1:0] acc;
        for (int r = 0; r < KSIZE; r++) begin
            acc = '0;
            for (int c = 0; c < KSIZE; c++) begin
                acc = acc + PART_W'(r_prod[r*KSIZE+c]);
            end
            n_part[r] = acc;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int r = 0; r < KSIZE; r++) begin
            n_sum = n_sum + SUM_W'(r_part[r]);
        end
    end

    // Adding the bias to a negative sum makes the arithmetic shift truncate toward zero.
    always_comb begin
        biased = {r_sum[SUM_W-1], r_sum} + (r_sum[SUM_W-1] ? BIAS : '0);
        quot   = biased >>> COEF_FRAC_BITS;
        if (quot > Q_MAX) begin
            n_val = VAL_W'(Q_MAX);
        end else if (quot < Q_MIN) begin
            n_val = VAL_W'(Q_MIN);
        end else begin
            n_val = VAL_W'(quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (p_rdy) begin
                r_p_valid <= i_valid;
            end
            if (a_rdy) begin
                r_a_valid <= r_p_valid;
            end
            if (t_rdy) begin
                r_t_valid <= r_a_valid;
            end
            if (o_rdy) begin
                r_o_valid <= r_t_valid && r_t_meta.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_rdy && i_valid) begin
            r_prod   <= n_prod;
            r_p_meta <= i_meta;
        end
        if (a_rdy && r_p_valid) begin
            r_part   <= n_part;
            r_a_meta <= r_p_meta;
        end
        if (t_rdy && r_a_valid) begin
            r_sum    <= n_sum;
            r_t_meta <= r_a_meta;
        end
        if (o_rdy && r_t_valid) begin
            r_word.filtered_value <= n_val;
            r_word.center_row     <= r_t_meta.center_row;
            r_word.center_col     <= r_t_meta.center_col;
            r_word.last_result    <= r_t_meta.last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

// ===== hdl/conv2d_5x5_stream.sv =====
// Top level of the streaming 5x5 convolution: counters, line store, window, config.
// Depends on c2d_pkg, c2d_ram and c2d_mac.
//
// Pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_in_word); a word is taken at a clock edge where valid is high and stall is low.
// Results leave on the output channel (o_out_valid, i_out_stall, o_out_word), one
// per pixel whose 5x5 window lies wholly inside the frame; border pixels give none.
// The block takes one pixel per clock while o_in_stall is low. The line store is a
// single memory with at most one read and one write each cycle, and a write is
// forwarded to a read of the same column made at the same clock edge.
// The edge that accepts a pixel also reads the line store; the pixel's result then
// passes through the window update, the multiply, the two adder levels and the
// rounding register.
// When the receiver stalls, the result holds and the stages behind it keep filling
// until they are full, after which o_in_stall rises.
// Synchronous reset clears pipeline, row and column counters and coefficients, and
// sets the line width to 256. Configuration is written via i_cfg_wr_en, i_cfg_index
// and i_cfg_wdata by the user while no pixel is in flight, unchecked by the block.
`default_nettype none

module conv2d_5x5_stream #(
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  c2d_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output c2d_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_wr_en,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [c2d_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    import c2d_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [WCMP_W-1:0] W_MIN = WCMP_W'(KSIZE);
    localparam logic [WCMP_W-1:0] W_MAX = WCMP_W'(MAX_WIDTH);

    logic [CFG_DATA_W-1:0] r_coef_word [CFG_COEF_WORDS];
    logic [COEF_W-1:0]     r_coef_tail;
    logic [LW_W-1:0]       r_line_width;
    logic [CW-1:0]         r_col;
    logic [ROW_CNT_W-1:0]  r_row;

    logic                  r_s1_valid;
    logic [PIX_W-1:0]      r_s1_pix;
    logic [CW-1:0]         r_s1_col;
    t_meta                 r_s1_meta;
    logic                  r_byp;
    logic [LINE_W-1:0]     r_byp_data;

    logic                  r_s2_valid;
    t_meta                 r_s2_meta;
    t_window               r_window;

    logic                  accept, s1_rdy, s2_rdy, s1_adv, mac_ready;
    logic [WCMP_W-1:0]     lw_ext, w_eff, col_next;
    logic [ROW_CNT_W-1:0]  row_m;
    logic [WCMP_W-1:0]     col_m;
    t_meta                 n_meta;
    logic [LINE_W-1:0]     ram_rdata, old_line, n_line;
    t_window               n_window;
    t_coefs                coefs;

    assign s2_rdy     = !r_s2_valid || mac_ready;
    assign s1_rdy     = !r_s1_valid || s2_rdy;
    assign s1_adv     = r_s1_valid && s2_rdy;
    assign accept     = i_in_valid && s1_rdy;
    assign o_in_stall = !s1_rdy;

    always_comb begin
        lw_ext = WCMP_W'(r_line_width);
        if (lw_ext < W_MIN) begin
            w_eff = W_MIN;
        end else if (lw_ext > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = lw_ext;
        end
        col_next = WCMP_W'(r_col) + WCMP_W'(1);
    end

    always_comb begin
        row_m             = r_row - ROW_CNT_W'(HALF);
        col_m             = WCMP_W'(r_col) - WCMP_W'(HALF);
        n_meta.emit       = (r_row >= ROW_CNT_W'(KSIZE - 1)) && (r_col >= CW'(KSIZE - 1));
        n_meta.center_row = (row_m > ROW_CNT_W'(ROW_SAT)) ? ROW_SAT : row_m[ROW_W-1:0];
        n_meta.center_col = col_m[COL_W-1:0];
        n_meta.last       = i_in_word.last_in_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (i_in_word.last_in_frame) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_next >= w_eff) begin
                r_col <= '0;
                if (r_row < ROW_CAP) begin
                    r_row <= r_row + ROW_CNT_W'(1);
                end
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COEF_WORDS; i++) begin
                r_coef_word[i] <= '0;
            end
            r_coef_tail  <= '0;
            r_line_width <= LW_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index) inside
                [CFG_COEF_FIRST:CFG_COEF_LAST]: begin
                    r_coef_word[i_cfg_index] <= i_cfg_wdata;
                end
                CFG_COEF_TAIL: begin
                    r_coef_tail <= i_cfg_wdata[COEF_W-1:0];
                end
                CFG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_wdata[LW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            if ((k >> 2) < CFG_COEF_WORDS) begin
                coefs[k] = r_coef_word[k >> 2][COEF_W*(k & (COEFS_PER_WORD-1)) +: COEF_W];
            end else begin
                coefs[k] = r_coef_tail;
            end
        end
    end

    c2d_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (n_line),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rdata)
    );

    assign old_line = r_byp ? r_byp_data : ram_rdata;
    assign n_line   = {old_line[LINE_W-PIX_W-1:0], r_s1_pix};

    // The window shifts left; the new column is the incoming pixel at the bottom
    // and the four stored pixels of this column above it, newest lowest.
    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            for (int c = 0; c < KSIZE - 1; c++) begin
                n_window[r*KSIZE+c] = r_window[r*KSIZE+c+1];
            end
        end
        n_window[NTAPS-1] = r_s1_pix;
        for (int t = 1; t < KSIZE; t++) begin
            n_window[(KSIZE-1-t)*KSIZE+KSIZE-1] = old_line[PIX_W*(t-1) +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_rdy) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_in_word.pixel;
            r_s1_col   <= r_col;
            r_s1_meta  <= n_meta;
            r_byp      <= s1_adv && (r_s1_col == r_col);
            r_byp_data <= n_line;
        end
        if (s1_adv) begin
            r_window  <= n_window;
            r_s2_meta <= r_s1_meta;
        end
    end

    c2d_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s2_valid),
        .o_ready  (mac_ready),
        .i_meta   (r_s2_meta),
        .i_window (r_window),
        .i_coefs  (coefs),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_word   (o_out_word)
    );

endmodule

`default_nettype wire

// ===== hdl/c2d_checker.sv =====
// Port-level checker for conv2d_5x5_stream and the bind that attaches it.
// Depends on c2d_pkg and the top level's port list.
`default_nettype none

module c2d_assertions (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input c2d_pkg::t_in_word                   i_in_word,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input c2d_pkg::t_out_word                  o_out_word
);

    import c2d_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present right after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    a_in_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("pixel word changed while stalled");

    a_center_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.center_col >= COL_W'(HALF))
                     && (o_out_word.center_row >= ROW_W'(HALF)))
        else $error("result reported for a border center");

endmodule

bind conv2d_5x5_stream c2d_assertions u_c2d_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
